// ===== rtl/lrrt_pkg.sv =====
// Shared types and constants for the live region range table.
`default_nettype none

package lrrt_pkg;

  localparam int REGION_ENTRIES = 64;
  localparam int IDX_W = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;
  localparam int CNT_W = $clog2(REGION_ENTRIES + 1);

  localparam int ADDR_W = 64;
  localparam int SIZE_W = 48;
  localparam int TYPE_W = 8;
  localparam int ENTRY_W = ADDR_W + SIZE_W + TYPE_W;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_STORE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_IGNORED      = 4'd1,
    ST_OVERLAP      = 4'd2,
    ST_WRAP         = 4'd3,
    ST_FULL         = 4'd4,
    ST_FREED        = 4'd5,
    ST_FREE_UNKNOWN = 4'd6,
    ST_HIT          = 4'd7,
    ST_MISS         = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic [TYPE_W-1:0] region_type;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    entry_t            hit_entry;
    logic [SIZE_W-1:0] offset;
    logic              slot_vld;
    logic [IDX_W-1:0]  slot_idx;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/lrrt_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lrrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lrrt_eval.sv =====
// Per-entry match evaluation and running best-match tracking for one scan.
`default_nettype none

module lrrt_eval (
  input  wire logic                      clk,
  input  wire logic                      clr,
  input  wire logic                      chk_vld,
  input  wire logic                      chk_live,
  input  wire logic [lrrt_pkg::IDX_W-1:0]  chk_idx,
  input  wire lrrt_pkg::entry_t           rd_entry,
  input  wire lrrt_pkg::cmd_t             cmd,
  input  wire logic [lrrt_pkg::ADDR_W-1:0] addr,
  input  wire logic [lrrt_pkg::ADDR_W-1:0] end_addr,
  output lrrt_pkg::scan_res_t             res
);

  import lrrt_pkg::*;

  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  entry_t            hit_entry_r;
  logic [SIZE_W-1:0] offset_r;
  logic              slot_vld_r;
  logic [IDX_W-1:0]  slot_idx_r;

  logic [ADDR_W:0]   ent_end;
  logic              ovl;
  logic [ADDR_W-1:0] acc_off;
  logic              contains;
  logic              exact;
  logic              lower;

  always_comb begin
    ent_end  = {1'b0, rd_entry.start} + {{(ADDR_W + 1 - SIZE_W){1'b0}}, rd_entry.size};
    ovl      = (rd_entry.start < end_addr) && (ent_end > {1'b0, addr});
    acc_off  = addr - rd_entry.start;
    contains = (addr >= rd_entry.start) &&
               (acc_off < {{(ADDR_W - SIZE_W){1'b0}}, rd_entry.size});
    exact    = (rd_entry.start == addr);
    lower    = !hit_r || (rd_entry.start < hit_entry_r.start);
  end

  always_ff @(posedge clk) begin
    if (!clr && chk_vld) begin
      unique case (cmd)
        CMD_ALLOC: begin
          if (chk_live && ovl && lower) begin
            hit_idx_r   <= chk_idx;
            hit_entry_r <= rd_entry;
          end
          if (!chk_live && !slot_vld_r) begin
            slot_idx_r <= chk_idx;
          end
        end
        CMD_FREE: begin
          if (chk_live && exact && !hit_r) begin
            hit_idx_r   <= chk_idx;
            hit_entry_r <= rd_entry;
          end
        end
        CMD_LOAD, CMD_STORE: begin
          if (chk_live && contains && !hit_r) begin
            hit_idx_r   <= chk_idx;
            hit_entry_r <= rd_entry;
            offset_r    <= acc_off[SIZE_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      hit_r      <= 1'b0;
      slot_vld_r <= 1'b0;
    end else if (chk_vld) begin
      unique case (cmd)
        CMD_ALLOC: begin
          if (chk_live && ovl) begin
            hit_r <= 1'b1;
          end
          if (!chk_live) begin
            slot_vld_r <= 1'b1;
          end
        end
        CMD_FREE: begin
          if (chk_live && exact) begin
            hit_r <= 1'b1;
          end
        end
        CMD_LOAD, CMD_STORE: begin
          if (chk_live && contains) begin
            hit_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.hit       = hit_r;
    res.hit_idx   = hit_idx_r;
    res.hit_entry = hit_entry_r;
    res.offset    = offset_r;
    res.slot_vld  = slot_vld_r;
    res.slot_idx  = slot_idx_r;
  end

endmodule

`default_nettype wire

// ===== rtl/live_region_range_table.sv =====
// Top level of the live region range table: sequencer, live bits, result register.
//
//   channel | ports                                            | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_stall, in_cmd, in_addr,              | item in
//           | in_region_len, in_type_id                         |
//   out     | out_valid, out_stall, out_status, out_region_*,   | item out
//           | out_access_offset                                 |
//
// Each item is accepted, scanned entry by entry through the single read port of the
// entry memory with a final scan step to cover read latency, and then committed. Reset
// clears the live bits at once; entry memory needs no clearing.
// A finished item waits in the output register while the next item is accepted and
// scanned; the commit holds only while that register is occupied and out_stall is high.
`default_nettype none

module live_region_range_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [lrrt_pkg::ADDR_W-1:0]   in_addr,
  input  wire logic [lrrt_pkg::SIZE_W-1:0]   in_region_len,
  input  wire logic [lrrt_pkg::TYPE_W-1:0]   in_type_id,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [3:0]                         out_status,
  output logic [lrrt_pkg::ADDR_W-1:0]        out_region_start,
  output logic [lrrt_pkg::SIZE_W-1:0]        out_region_size,
  output logic [lrrt_pkg::TYPE_W-1:0]        out_region_type,
  output logic [lrrt_pkg::SIZE_W-1:0]        out_access_offset
);

  import lrrt_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  cmd_t              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SIZE_W-1:0] len_r;
  logic [TYPE_W-1:0] type_r;
  logic [ADDR_W-1:0] end_r;
  logic              wrap_r;

  logic [REGION_ENTRIES-1:0] live_r;
  logic              chk_vld_r;
  logic              chk_live_r;
  logic [IDX_W-1:0]  chk_idx_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_start_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [TYPE_W-1:0] out_type_r;
  logic [SIZE_W-1:0] out_off_r;

  logic              accept;
  logic              scan_issue;
  logic              scan_last;
  logic              done_go;
  logic [IDX_W-1:0]  scan_idx;
  logic [ADDR_W:0]   sum_in;

  entry_t            rd_entry;
  entry_t            wr_entry;
  scan_res_t         res;

  status_t           res_status;
  logic [ADDR_W-1:0] res_start;
  logic [SIZE_W-1:0] res_size;
  logic [TYPE_W-1:0] res_type;
  logic [SIZE_W-1:0] res_off;
  logic              do_insert;
  logic              do_erase;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (done_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    scan_last  = (cnt_r == CNT_W'(REGION_ENTRIES));
    scan_idx   = cnt_r[IDX_W-1:0];
    accept     = (state_r == S_IDLE) && in_valid;
    scan_issue = (state_r == S_SCAN) && !scan_last;
    done_go    = (state_r == S_DONE) && (!out_valid_r || !out_stall);
    in_stall   = (state_r != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign sum_in = {1'b0, in_addr} + {{(ADDR_W + 1 - SIZE_W){1'b0}}, in_region_len};

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_t'(in_cmd);
      addr_r <= in_addr;
      len_r  <= in_region_len;
      type_r <= in_type_id;
      end_r  <= sum_in[ADDR_W-1:0];
      wrap_r <= sum_in[ADDR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else begin
      chk_vld_r <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      chk_live_r <= live_r[scan_idx];
      chk_idx_r  <= scan_idx;
    end
  end

  assign wr_entry.start       = addr_r;
  assign wr_entry.size        = len_r;
  assign wr_entry.region_type = type_r;

  lrrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (REGION_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (do_insert),
    .wr_addr (res.slot_idx),
    .wr_data (wr_entry),
    .rd_en   (scan_issue),
    .rd_addr (scan_idx),
    .rd_data (rd_entry)
  );

  lrrt_eval u_eval (
    .clk      (clk),
    .clr      (accept),
    .chk_vld  (chk_vld_r),
    .chk_live (chk_live_r),
    .chk_idx  (chk_idx_r),
    .rd_entry (rd_entry),
    .cmd      (cmd_r),
    .addr     (addr_r),
    .end_addr (end_r),
    .res      (res)
  );

  // result selection
  always_comb begin
    res_status = ST_MISS;
    res_start  = '0;
    res_size   = '0;
    res_type   = '0;
    res_off    = '0;
    do_insert  = 1'b0;
    do_erase   = 1'b0;
    unique case (cmd_r)
      CMD_ALLOC: begin
        priority if (addr_r == '0 || len_r == '0) begin
          res_status = ST_IGNORED;
        end else if (wrap_r) begin
          res_status = ST_WRAP;
          res_start  = addr_r;
          res_size   = len_r;
          res_type   = type_r;
        end else if (res.hit) begin
          res_status = ST_OVERLAP;
          res_start  = res.hit_entry.start;
          res_size   = res.hit_entry.size;
          res_type   = res.hit_entry.region_type;
        end else if (!res.slot_vld) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_OK;
          res_start  = addr_r;
          res_size   = len_r;
          res_type   = type_r;
          do_insert  = done_go;
        end
      end
      CMD_FREE: begin
        if (res.hit) begin
          res_status = ST_FREED;
          res_start  = res.hit_entry.start;
          res_size   = res.hit_entry.size;
          res_type   = res.hit_entry.region_type;
          do_erase   = done_go;
        end else begin
          res_status = ST_FREE_UNKNOWN;
          res_start  = addr_r;
        end
      end
      CMD_LOAD, CMD_STORE: begin
        if (res.hit) begin
          res_status = ST_HIT;
          res_start  = res.hit_entry.start;
          res_size   = res.hit_entry.size;
          res_type   = res.hit_entry.region_type;
          res_off    = res.offset;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (do_insert) begin
      live_r[res.slot_idx] <= 1'b1;
    end else if (do_erase) begin
      live_r[res.hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_status_r <= res_status;
      out_start_r  <= res_start;
      out_size_r   <= res_size;
      out_type_r   <= res_type;
      out_off_r    <= res_off;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_region_start  = out_start_r;
  assign out_region_size   = out_size_r;
  assign out_region_type   = out_type_r;
  assign out_access_offset = out_off_r;

endmodule

`default_nettype wire

// ===== tb/tb_live_region_range_table.sv =====
// Testbench for the live region range table: queued requests, table predictor, reply checker.
`timescale 1ns / 100ps

module tb_live_region_range_table;
  import lrrt_pkg::*;

  typedef struct {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] len;
    logic [TYPE_W-1:0] tid;
    bit                hold;
  } table_req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic [TYPE_W-1:0] rtype;
    logic [SIZE_W-1:0] offset;
  } region_reply_t;

  typedef struct {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] len;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  cmd_t              in_cmd = CMD_ALLOC;
  logic [ADDR_W-1:0] in_addr = '0;
  logic [SIZE_W-1:0] in_region_len = '0;
  logic [TYPE_W-1:0] in_type_id = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [3:0]        out_status;
  logic [ADDR_W-1:0] out_region_start;
  logic [SIZE_W-1:0] out_region_size;
  logic [TYPE_W-1:0] out_region_type;
  logic [SIZE_W-1:0] out_access_offset;

  table_req_t    req_q[$];
  region_reply_t reply_q[$];
  span_t         known_q[$];

  bit                tbl_live [REGION_ENTRIES];
  logic [ADDR_W-1:0] tbl_start [REGION_ENTRIES];
  logic [SIZE_W-1:0] tbl_size [REGION_ENTRIES];
  logic [TYPE_W-1:0] tbl_type [REGION_ENTRIES];

  int n_err = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  live_region_range_table u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_addr           (in_addr),
    .in_region_len     (in_region_len),
    .in_type_id        (in_type_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_region_start  (out_region_start),
    .out_region_size   (out_region_size),
    .out_region_type   (out_region_type),
    .out_access_offset (out_access_offset)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic region_reply_t apply_request(cmd_t cmd, logic [ADDR_W-1:0] addr,
                                                  logic [SIZE_W-1:0] len,
                                                  logic [TYPE_W-1:0] tid);
    region_reply_t r;
    logic [ADDR_W:0] lim;
    logic [ADDR_W:0] r_lim;
    logic [ADDR_W-1:0] off;
    int hit_i;
    int slot_i;
    bit found;
    r.status = ST_MISS;
    r.start = '0;
    r.size = '0;
    r.rtype = '0;
    r.offset = '0;
    hit_i = -1;
    slot_i = -1;
    found = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        lim = {1'b0, addr} + {17'b0, len};
        if (addr == '0 || len == '0) begin
          r.status = ST_IGNORED;
        end else if (lim[ADDR_W]) begin
          r.status = ST_WRAP;
          r.start = addr;
          r.size = len;
          r.rtype = tid;
        end else begin
          for (int i = 0; i < REGION_ENTRIES; i++) begin
            if (tbl_live[i]) begin
              r_lim = {1'b0, tbl_start[i]} + {17'b0, tbl_size[i]};
              if ({1'b0, tbl_start[i]} < lim && r_lim > {1'b0, addr} &&
                  (hit_i < 0 || tbl_start[i] < tbl_start[hit_i]))
                hit_i = i;
            end else if (slot_i < 0) begin
              slot_i = i;
            end
          end
          if (hit_i >= 0) begin
            r.status = ST_OVERLAP;
            r.start = tbl_start[hit_i];
            r.size = tbl_size[hit_i];
            r.rtype = tbl_type[hit_i];
          end else if (slot_i < 0) begin
            r.status = ST_FULL;
          end else begin
            tbl_live[slot_i] = 1'b1;
            tbl_start[slot_i] = addr;
            tbl_size[slot_i] = len;
            tbl_type[slot_i] = tid;
            r.status = ST_OK;
            r.start = addr;
            r.size = len;
            r.rtype = tid;
          end
        end
      end
      CMD_FREE: begin
        r.status = ST_FREE_UNKNOWN;
        r.start = addr;
        for (int i = 0; i < REGION_ENTRIES; i++) begin
          if (!found && tbl_live[i] && tbl_start[i] == addr) begin
            found = 1'b1;
            tbl_live[i] = 1'b0;
            r.status = ST_FREED;
            r.size = tbl_size[i];
            r.rtype = tbl_type[i];
          end
        end
      end
      default: begin
        for (int i = 0; i < REGION_ENTRIES; i++) begin
          off = addr - tbl_start[i];
          if (!found && tbl_live[i] && addr >= tbl_start[i] && off < {16'b0, tbl_size[i]}) begin
            found = 1'b1;
            r.status = ST_HIT;
            r.start = tbl_start[i];
            r.size = tbl_size[i];
            r.rtype = tbl_type[i];
            r.offset = off[SIZE_W-1:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic push_req(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] len,
                          logic [TYPE_W-1:0] tid, bit hold);
    table_req_t r;
    span_t sp;
    r.cmd = cmd;
    r.addr = addr;
    r.len = len;
    r.tid = tid;
    r.hold = hold;
    req_q.push_back(r);
    if (cmd == CMD_ALLOC && addr != '0 && len != '0) begin
      sp.start = addr;
      sp.len = len;
      known_q.push_back(sp);
      if (known_q.size() > 200) void'(known_q.pop_front());
    end
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    span_t sp;
    logic [ADDR_W-1:0] off;
    case ($urandom_range(0, 9))
      0, 1: return {$urandom, $urandom};
      2: return ~64'($urandom_range(0, 255));
      3: return 64'($urandom_range(0, 15));
      default: begin
        if (known_q.size() == 0) return {$urandom, $urandom};
        sp = known_q[$urandom_range(0, known_q.size() - 1)];
        off = {$urandom, $urandom} % ({16'b0, sp.len} + 64'd2);
        return sp.start + off - 64'd1;
      end
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 48'({$urandom, $urandom});
      default: return 48'($urandom_range(1, 'h2_0000));
    endcase
  endfunction

  always @(posedge clk) begin : driver
    table_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reply_q.push_back(apply_request(in_cmd, in_addr, in_region_len, in_type_id));
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 3);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          if (!in_stall) tx_gap--;
        end else if (req_q.size() != 0 && !(req_q[0].hold && reply_q.size() != 0)) begin
          nxt = req_q.pop_front();
          in_valid <= 1'b1;
          in_cmd <= nxt.cmd;
          in_addr <= nxt.addr;
          in_region_len <= nxt.len;
          in_type_id <= nxt.tid;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    region_reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected item, got st=%0d start=%h size=%h type=%h off=%h",
                   $time, out_status, out_region_start, out_region_size,
                   out_region_type, out_access_offset);
        end else begin
          want = reply_q.pop_front();
          if (out_status != want.status || out_region_start != want.start ||
              out_region_size != want.size || out_region_type != want.rtype ||
              out_access_offset != want.offset) begin
            n_err++;
            $display("%0t: mismatch, expected st=%0d start=%h size=%h type=%h off=%h",
                     $time, want.status, want.start, want.size, want.rtype, want.offset);
            $display("%0t: mismatch, actual   st=%0d start=%h size=%h type=%h off=%h",
                     $time, out_status, out_region_start, out_region_size,
                     out_region_type, out_access_offset);
          end
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
      end else if (out_valid && rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait > 0);
    end
  end

  initial begin : stimulus
    int n_rand;
    int burst;
    int kind;
    int idx;
    logic [ADDR_W-1:0] base;
    span_t sp;
    push_req(CMD_LOAD, '0, '0, '0, 1'b0);
    push_req(CMD_FREE, '0, '0, '0, 1'b0);
    push_req(CMD_ALLOC, '0, 48'd5, 8'h11, 1'b0);
    push_req(CMD_ALLOC, 64'h1000, '0, 8'h22, 1'b0);
    push_req(CMD_ALLOC, '1, 48'd1, 8'h33, 1'b0);
    push_req(CMD_ALLOC, 64'hFFFF_FFFF_FFFF_0000, '1, 8'h44, 1'b0);
    push_req(CMD_ALLOC, 64'hFFFF_FFFF_FFFF_FFFE, 48'd1, 8'hFF, 1'b0);
    push_req(CMD_ALLOC, 64'h1, '1, 8'h00, 1'b0);
    push_req(CMD_ALLOC, 64'h1_0000_0000_0000, 48'h100, 8'hA5, 1'b0);
    push_req(CMD_ALLOC, 64'h1000, 48'h10, 8'h5A, 1'b0);
    push_req(CMD_ALLOC, 64'h1_0000_0000_0000, 48'd1, 8'h66, 1'b0);
    push_req(CMD_ALLOC, 64'hFFFF_FFFF_FF00, 48'h200, 8'h77, 1'b0);
    push_req(CMD_LOAD, 64'h1, '0, '0, 1'b0);
    push_req(CMD_STORE, 64'hFFFF_FFFF_FFFF, '0, '0, 1'b0);
    push_req(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0, 1'b0);
    push_req(CMD_LOAD, '1, '0, '0, 1'b0);
    push_req(CMD_LOAD, 64'h1_0000_0000_0100, '0, '0, 1'b0);
    push_req(CMD_FREE, 64'h2, '0, '0, 1'b0);
    push_req(CMD_FREE, 64'h1, '0, '0, 1'b0);
    push_req(CMD_LOAD, 64'h5, '0, '0, 1'b0);
    push_req(CMD_FREE, 64'h1, '0, '0, 1'b0);

    n_rand = 0;
    kind = 0;
    while (n_rand < 500) begin
      case (kind)
        0, 1: begin
          base = 64'($urandom_range(1, 4095)) << 28;
          burst = (n_rand == 0) ? 70 : $urandom_range(10, 40);
          for (int k = 0; k < burst; k++) begin
            push_req(CMD_ALLOC, base + 64'(k) * 64'h1_0000, 48'($urandom_range(1, 'h1_0000)),
                     8'($urandom), n_rand == 0);
            n_rand++;
          end
        end
        6, 7: begin
          burst = $urandom_range(10, 30);
          for (int k = 0; k < burst && known_q.size() != 0; k++) begin
            sp = known_q[$urandom_range(0, known_q.size() - 1)];
            push_req(cmd_t'($urandom_range(2, 3)),
                     sp.start + ({$urandom, $urandom} % {16'b0, sp.len}),
                     48'({$urandom, $urandom}), 8'($urandom), 1'b0);
            n_rand++;
          end
        end
        8, 9: begin
          burst = $urandom_range(10, 40);
          for (int k = 0; k < burst && known_q.size() != 0; k++) begin
            idx = $urandom_range(0, known_q.size() - 1);
            sp = known_q[idx];
            known_q.delete(idx);
            push_req(CMD_FREE, sp.start, pick_len(), 8'($urandom), k == 0);
            n_rand++;
          end
        end
        default: begin
          burst = $urandom_range(10, 40);
          for (int k = 0; k < burst; k++) begin
            push_req(cmd_t'($urandom_range(0, 3)), pick_addr(), pick_len(), 8'($urandom),
                     1'b0);
            n_rand++;
          end
        end
      endcase
      kind = $urandom_range(0, 9);
    end

    while (req_q.size() != 0 || in_valid || reply_q.size() != 0) @(posedge clk);
    repeat (2 * REGION_ENTRIES) @(posedge clk);
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
